// File: design/ffa_pkg.sv
// Shared codes and constants for the first-fit block allocator.
package ffa_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;
  localparam logic [1:0] ST_BAD_ADDR = 2'd3;

  localparam logic CFG_POOL_BASE  = 1'b0;
  localparam logic CFG_POOL_BYTES = 1'b1;

  localparam int unsigned AlignBytes = 8;

endpackage

// File: design/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: configuration registers and table.
// One command at a time: busy is high from the cycle after a command is accepted
// and drops in the cycle in which done_o is high, so the next command can be taken
// at the edge that ends that cycle. A zero-size allocate never raises busy and
// shows done_o in the cycle after it is accepted. The single table read port sets
// the pace: an allocate reads and checks each block, and a split moves the later
// entries up one place before the tail block is inserted; a free scans for the block,
// marks it free, then merges each pair of adjacent free blocks, moving the later
// entries down one place on each merge. Writing pool_bytes while idle rebuilds the
// table. The result beat is shown for one cycle on done_o and cannot be held off.
module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS         = 64,
  parameter int unsigned HEADER_BYTES       = 24,
  parameter int unsigned ARENA_HEADER_BYTES = 24,
  parameter int unsigned POOL_ADDR_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [15:0] request_bytes_i,
  input  logic [31:0] free_address_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] data_address_o
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned EW = 2 * POOL_ADDR_BITS + 1;

  logic [31:0]   pool_base_q;
  logic [15:0]   pool_bytes_q;
  logic          init_req, idle;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  assign init_req = cfg_we_i && (cfg_idx_i == ffa_pkg::CFG_POOL_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      pool_bytes_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ffa_pkg::CFG_POOL_BASE) begin
        pool_base_q <= cfg_data_i;
      end else begin
        pool_bytes_q <= cfg_data_i[15:0];
      end
    end
  end

  assign busy = !idle || init_req;

  ffa_seq #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES),
    .ARENA_HEADER_BYTES(ARENA_HEADER_BYTES),
    .POOL_ADDR_BITS(POOL_ADDR_BITS)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .init_req_i(init_req),
    .pool_base_i(pool_base_q),
    .pool_bytes_i(pool_bytes_q),
    .start_i(start && !busy),
    .cmd_i,
    .request_bytes_i,
    .free_address_i,
    .idle_o(idle),
    .done_o,
    .status_o,
    .data_address_o,
    .mem_we_o(mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o(mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  ffa_mem #(
    .DEPTH(MAX_BLOCKS),
    .WIDTH(EW)
  ) u_mem (
    .clk_i,
    .we_i(mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i(mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

// File: design/ffa_mem.sv
// Block table memory: one write port, one registered read port.
module ffa_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ffa_seq.sv
// Sequencer that walks the block table for allocate, free, merge and setup.
module ffa_seq #(
  parameter int unsigned MAX_BLOCKS         = 64,
  parameter int unsigned HEADER_BYTES       = 24,
  parameter int unsigned ARENA_HEADER_BYTES = 24,
  parameter int unsigned POOL_ADDR_BITS     = 16,
  localparam int unsigned IW = $clog2(MAX_BLOCKS),
  localparam int unsigned CW = IW + 1,
  localparam int unsigned P  = POOL_ADDR_BITS,
  localparam int unsigned EW = 2 * POOL_ADDR_BITS + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          init_req_i,
  input  logic [31:0]   pool_base_i,
  input  logic [15:0]   pool_bytes_i,
  input  logic          start_i,
  input  logic          cmd_i,
  input  logic [15:0]   request_bytes_i,
  input  logic [31:0]   free_address_i,
  output logic          idle_o,
  output logic          done_o,
  output logic [1:0]    status_o,
  output logic [31:0]   data_address_o,
  output logic          mem_we_o,
  output logic [IW-1:0] mem_waddr_o,
  output logic [EW-1:0] mem_wdata_o,
  output logic          mem_re_o,
  output logic [IW-1:0] mem_raddr_o,
  input  logic [EW-1:0] mem_rdata_i
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_ARD, S_AEV, S_SHRD, S_SHWR, S_INS, S_FIX,
    S_FRD, S_FEV, S_FWR, S_M0, S_M0E, S_MRD, S_MEV, S_RMRD, S_RMWR
  } state_e;

  localparam logic [31:0] OffMask = 32'((64'd1 << POOL_ADDR_BITS) - 64'd1);
  localparam logic [31:0] MinPool = 32'(ARENA_HEADER_BYTES + HEADER_BYTES);

  state_e        state_q;
  logic [CW-1:0] cnt_q, i_q, k_q;
  logic [16:0]   need_q;
  logic [31:0]   addr_q;
  logic [P-1:0]  cur_off_q, cur_len_q;
  logic          cur_free_q;
  logic          done_q;
  logic [1:0]    status_q;
  logic [31:0]   data_q;

  logic [P-1:0]  rd_off, rd_len;
  logic          rd_free;
  logic [31:0]   size;
  logic          fits, split, addr_hit, both_free;
  logic [CW-1:0] i_p1, k_p1;
  logic [P-1:0]  tail_off, tail_len, merge_len;
  logic [31:0]   rd_data_addr;

  assign rd_off  = mem_rdata_i[P-1:0];
  assign rd_len  = mem_rdata_i[2*P-1:P];
  assign rd_free = mem_rdata_i[2*P];
  assign size    = 32'(pool_bytes_i) & OffMask;
  assign i_p1    = i_q + CW'(1);
  assign k_p1    = k_q + CW'(1);

  assign fits  = rd_free && (34'(rd_len) >= 34'(need_q));
  assign split = (34'(rd_len) >= 34'(need_q) + 34'(HEADER_BYTES) + 34'(ffa_pkg::AlignBytes))
                 && (cnt_q < CW'(MAX_BLOCKS));
  assign tail_off  = P'(34'(cur_off_q) + 34'(HEADER_BYTES) + 34'(need_q));
  assign tail_len  = P'(34'(cur_len_q) - 34'(need_q) - 34'(HEADER_BYTES));
  assign merge_len = P'(34'(cur_len_q) + 34'(HEADER_BYTES) + 34'(rd_len));
  assign rd_data_addr = pool_base_i + 32'(rd_off) + 32'(HEADER_BYTES);
  assign addr_hit  = (rd_data_addr == addr_q);
  assign both_free = cur_free_q && rd_free;

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = i_q[IW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = i_q[IW-1:0];
    unique case (state_q)
      S_INIT: begin
        mem_we_o    = (size >= MinPool);
        mem_waddr_o = '0;
        mem_wdata_o = {1'b1, P'(size - MinPool), P'(ARENA_HEADER_BYTES)};
      end
      S_ARD, S_FRD: begin
        mem_re_o = (i_q < cnt_q);
      end
      S_AEV: begin
        mem_we_o    = fits && !split;
        mem_wdata_o = {1'b0, rd_len, rd_off};
      end
      S_SHRD: begin
        mem_re_o    = (k_q != i_p1);
        mem_raddr_o = IW'(k_q - CW'(1));
      end
      S_SHWR, S_RMWR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = k_q[IW-1:0];
      end
      S_INS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = i_p1[IW-1:0];
        mem_wdata_o = {1'b1, tail_len, tail_off};
      end
      S_FIX: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {1'b0, P'(need_q), cur_off_q};
      end
      S_FWR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {1'b1, cur_len_q, cur_off_q};
      end
      S_M0: begin
        mem_re_o    = (cnt_q >= CW'(2));
        mem_raddr_o = '0;
      end
      S_MRD: begin
        mem_re_o    = (i_p1 < cnt_q);
        mem_raddr_o = i_p1[IW-1:0];
      end
      S_MEV: begin
        mem_we_o    = both_free;
        mem_wdata_o = {1'b1, merge_len, cur_off_q};
      end
      S_RMRD: begin
        mem_re_o    = (k_p1 < cnt_q);
        mem_raddr_o = k_p1[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cnt_q      <= '0;
      i_q        <= '0;
      k_q        <= '0;
      need_q     <= '0;
      addr_q     <= '0;
      cur_off_q  <= '0;
      cur_len_q  <= '0;
      cur_free_q <= 1'b0;
      done_q     <= 1'b0;
      status_q   <= ffa_pkg::ST_OK;
      data_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_INIT: begin
          cnt_q   <= (size >= MinPool) ? CW'(1) : CW'(0);
          state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (init_req_i) begin
            state_q <= S_INIT;
          end else if (start_i) begin
            i_q    <= '0;
            need_q <= (17'(request_bytes_i) + 17'(ffa_pkg::AlignBytes - 1))
                      & ~17'(ffa_pkg::AlignBytes - 1);
            addr_q <= free_address_i;
            data_q <= '0;
            if (cmd_i == ffa_pkg::CMD_FREE) begin
              state_q <= S_FRD;
            end else if (request_bytes_i == 16'd0) begin
              status_q <= ffa_pkg::ST_ZERO;
              done_q   <= 1'b1;
            end else begin
              state_q <= S_ARD;
            end
          end
        end
        S_ARD: begin
          if (i_q < cnt_q) begin
            state_q <= S_AEV;
          end else begin
            status_q <= ffa_pkg::ST_NO_FIT;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        S_AEV: begin
          if (fits) begin
            cur_off_q <= rd_off;
            cur_len_q <= rd_len;
            data_q    <= rd_data_addr;
            if (split) begin
              k_q     <= cnt_q;
              state_q <= S_SHRD;
            end else begin
              status_q <= ffa_pkg::ST_OK;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end
          end else begin
            i_q     <= i_p1;
            state_q <= S_ARD;
          end
        end
        S_SHRD: begin
          state_q <= (k_q != i_p1) ? S_SHWR : S_INS;
        end
        S_SHWR: begin
          k_q     <= k_q - CW'(1);
          state_q <= S_SHRD;
        end
        S_INS: begin
          cnt_q   <= cnt_q + CW'(1);
          state_q <= S_FIX;
        end
        S_FIX: begin
          status_q <= ffa_pkg::ST_OK;
          done_q   <= 1'b1;
          state_q  <= S_IDLE;
        end
        S_FRD: begin
          if (i_q < cnt_q) begin
            state_q <= S_FEV;
          end else begin
            status_q <= ffa_pkg::ST_BAD_ADDR;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        S_FEV: begin
          if (addr_hit) begin
            cur_off_q <= rd_off;
            cur_len_q <= rd_len;
            state_q   <= S_FWR;
          end else begin
            i_q     <= i_p1;
            state_q <= S_FRD;
          end
        end
        S_FWR: begin
          state_q <= S_M0;
        end
        S_M0: begin
          i_q     <= '0;
          state_q <= (cnt_q >= CW'(2)) ? S_M0E : S_MRD;
        end
        S_M0E: begin
          cur_off_q  <= rd_off;
          cur_len_q  <= rd_len;
          cur_free_q <= rd_free;
          state_q    <= S_MRD;
        end
        S_MRD: begin
          if (i_p1 < cnt_q) begin
            state_q <= S_MEV;
          end else begin
            status_q <= ffa_pkg::ST_OK;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        S_MEV: begin
          if (both_free) begin
            cur_len_q <= merge_len;
            k_q       <= i_p1;
            state_q   <= S_RMRD;
          end else begin
            cur_off_q  <= rd_off;
            cur_len_q  <= rd_len;
            cur_free_q <= rd_free;
            i_q        <= i_p1;
            state_q    <= S_MRD;
          end
        end
        S_RMRD: begin
          if (k_p1 < cnt_q) begin
            state_q <= S_RMWR;
          end else begin
            cnt_q   <= cnt_q - CW'(1);
            state_q <= S_MRD;
          end
        end
        S_RMWR: begin
          k_q     <= k_p1;
          state_q <= S_RMRD;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign idle_o         = (state_q == S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign data_address_o = data_q;

endmodule
